>>> design/psr_pkg.sv
// Shared types and codes for the pursuit step and range detector.
// Holds command codes, register indexes, controller states and the
// controller-to-datapath command and status structs.
package psr_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] CMD_MOVE   = 2'd0;
  localparam logic [1:0] CMD_DETECT = 2'd1;
  localparam logic [1:0] CMD_PLACE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b1;

  localparam int RADIUS_RESET_UNITS = 10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SQX,
    ST_SQY,
    ST_SQR,
    ST_CMP,
    ST_ROOT,
    ST_MSX,
    ST_MSY,
    ST_DINIT,
    ST_DIV,
    ST_FIN
  } psr_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DELTA,
    OP_SQX,
    OP_SQY,
    OP_SQR,
    OP_CMP,
    OP_ROOT,
    OP_MSX,
    OP_MSY,
    OP_DINIT,
    OP_DIV,
    OP_FIN
  } psr_op_t;

  typedef struct packed {
    psr_op_t op;
  } psr_cmd_t;

  typedef struct packed {
    logic need_root;
    logic out_busy;
  } psr_stat_t;

endpackage

>>> design/psr_in_if.sv
// Request channel carrying a command and a target point.
// Depends on nothing beyond its width parameter.
interface psr_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;

  modport source (output valid, output cmd, output target_x, output target_y, input ready);
  modport sink   (input valid, input cmd, input target_x, input target_y, output ready);
endinterface

>>> design/psr_out_if.sv
// Result channel carrying the position and the detect and arrival flags.
// Depends on nothing beyond its width parameter.
interface psr_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic                          detected;
  logic                          arrived;

  modport source (output valid, output pos_x, output pos_y, output detected, output arrived,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input detected, input arrived,
                  output ready);
endinterface

>>> design/psr_cfg_if.sv
// Configuration write channel: register index and write data.
// Uses psr_pkg for the index width.
interface psr_cfg_if #(parameter int COORD_WIDTH = 32);
  import psr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [COORD_WIDTH-2:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/psr_ctrl.sv
// Controller state machine: sequences delta, squares, compare, root and division.
// Uses psr_pkg for states, ops and the command and status structs.
module psr_ctrl #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  psr_pkg::psr_stat_t stat,
  output psr_pkg::psr_cmd_t  cmd
);
  import psr_pkg::*;

  localparam int CW = $clog2(COORD_WIDTH + 2);
  localparam logic [CW-1:0] ROOT_LAST = CW'(COORD_WIDTH + 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(COORD_WIDTH - 2);

  psr_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.op    = OP_DELTA;
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        cmd.op    = OP_SQY;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.op    = OP_SQR;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.op    = OP_CMP;
        count_nxt = ROOT_LAST;
        state_nxt = stat.need_root ? ST_ROOT : ST_FIN;
      end
      ST_ROOT: begin
        cmd.op    = OP_ROOT;
        count_nxt = count_r - 1'b1;
        if (count_r == '0) begin
          state_nxt = ST_MSX;
        end
      end
      ST_MSX: begin
        cmd.op    = OP_MSX;
        state_nxt = ST_MSY;
      end
      ST_MSY: begin
        cmd.op    = OP_MSY;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.op    = OP_DINIT;
        count_nxt = DIV_LAST;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op    = OP_DIV;
        count_nxt = count_r - 1'b1;
        if (count_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/psr_dp.sv
// Datapath: position, configuration registers, shared multiplier,
// bit-serial square root, two-lane restoring divider and the result register.
// Uses psr_pkg for codes and the command and status structs.
module psr_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  psr_pkg::psr_cmd_t                     cmd,
  output psr_pkg::psr_stat_t                    stat,
  input  logic [1:0]                            in_cmd,
  input  logic signed [COORD_WIDTH-1:0]         in_tx,
  input  logic signed [COORD_WIDTH-1:0]         in_ty,
  input  logic                                  cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [COORD_WIDTH-2:0]                cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [COORD_WIDTH-1:0]         out_x,
  output logic signed [COORD_WIDTH-1:0]         out_y,
  output logic                                  out_det,
  output logic                                  out_arr
);
  import psr_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int MW   = W + 1;
  localparam int PW   = 2 * MW;
  localparam int SUMW = PW + 1;
  localparam int SI   = (SUMW + 1) / 2;
  localparam int RADW = 2 * SI;
  localparam int SRW  = SI + 2;
  localparam int QW   = W - 1;
  localparam int RW   = W - 1;
  localparam logic [RW-1:0] RADIUS_RST = RW'(64'(RADIUS_RESET_UNITS) << FRAC_BITS);

  logic [RW-1:0]        step_r, radius_r;
  logic [1:0]           cmd_r;
  logic signed [W-1:0]  tx_r, ty_r, cur_x_r, cur_y_r;
  logic signed [W-1:0]  cur_x_nxt, cur_y_nxt;
  logic [MW-1:0]        mag_x_r, mag_y_r, dx_w, dy_w;
  logic                 neg_x_r, neg_y_r;
  logic [MW-1:0]        mul_a, mul_b, ref_v;
  logic [PW-1:0]        prod_r;
  logic [SUMW-1:0]      sum_r;
  logic                 gt, gt_r;
  logic [RADW-1:0]      rad_r;
  logic [SI-1:0]        root_r;
  logic [SRW-1:0]       srem_r;
  logic [SRW+1:0]       rem_sh, trial;
  logic [SI-1:0]        drem_x_r, drem_y_r;
  logic [QW-1:0]        dq_x_r, dq_y_r;
  logic [SI:0]          dtx, dty, dvs;
  logic                 det_nxt, arr_nxt;
  logic                 out_valid_r;
  logic signed [W-1:0]  out_x_r, out_y_r;
  logic                 out_det_r, out_arr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STEP:   step_r   <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data;
        default:    step_r   <= step_r;
      endcase
    end
  end

  assign dx_w  = {tx_r[W-1], tx_r} - {cur_x_r[W-1], cur_x_r};
  assign dy_w  = {ty_r[W-1], ty_r} - {cur_y_r[W-1], cur_y_r};
  assign ref_v = (cmd_r == CMD_MOVE) ? MW'(step_r) : MW'(radius_r);

  always_comb begin
    mul_a = mag_x_r;
    mul_b = mag_x_r;
    unique case (cmd.op)
      OP_SQY: begin
        mul_a = mag_y_r;
        mul_b = mag_y_r;
      end
      OP_SQR: begin
        mul_a = ref_v;
        mul_b = ref_v;
      end
      OP_MSX: begin
        mul_a = mag_x_r;
        mul_b = MW'(step_r);
      end
      OP_MSY: begin
        mul_a = mag_y_r;
        mul_b = MW'(step_r);
      end
      default: begin
        mul_a = mag_x_r;
        mul_b = mag_x_r;
      end
    endcase
  end

  assign gt             = sum_r > SUMW'(prod_r);
  assign stat.need_root = (cmd_r == CMD_MOVE) && gt;
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign rem_sh = {srem_r, rad_r[RADW-1 -: 2]};
  assign trial  = (SRW+2)'({root_r, 2'b01});
  assign dvs    = {1'b0, root_r};
  assign dtx    = {drem_x_r, dq_x_r[QW-1]};
  assign dty    = {drem_y_r, dq_y_r[QW-1]};

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    det_nxt   = 1'b0;
    arr_nxt   = 1'b0;
    unique case (cmd_r)
      CMD_MOVE: begin
        if (gt_r) begin
          cur_x_nxt = neg_x_r ? cur_x_r - {1'b0, dq_x_r} : cur_x_r + {1'b0, dq_x_r};
          cur_y_nxt = neg_y_r ? cur_y_r - {1'b0, dq_y_r} : cur_y_r + {1'b0, dq_y_r};
        end else begin
          cur_x_nxt = tx_r;
          cur_y_nxt = ty_r;
          arr_nxt   = 1'b1;
        end
      end
      CMD_DETECT: det_nxt = !gt_r;
      CMD_PLACE: begin
        cur_x_nxt = tx_r;
        cur_y_nxt = ty_r;
      end
      default: det_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r <= in_cmd;
        tx_r  <= in_tx;
        ty_r  <= in_ty;
      end
      OP_DELTA: begin
        neg_x_r <= dx_w[MW-1];
        neg_y_r <= dy_w[MW-1];
        mag_x_r <= dx_w[MW-1] ? (~dx_w + MW'(1)) : dx_w;
        mag_y_r <= dy_w[MW-1] ? (~dy_w + MW'(1)) : dy_w;
      end
      OP_SQX: prod_r <= mul_a * mul_b;
      OP_SQY: begin
        prod_r <= mul_a * mul_b;
        sum_r  <= SUMW'(prod_r);
      end
      OP_SQR: begin
        prod_r <= mul_a * mul_b;
        sum_r  <= sum_r + SUMW'(prod_r);
      end
      OP_CMP: begin
        gt_r   <= gt;
        rad_r  <= RADW'(sum_r);
        root_r <= '0;
        srem_r <= '0;
      end
      OP_ROOT: begin
        rad_r <= rad_r << 2;
        if (rem_sh >= trial) begin
          srem_r <= SRW'(rem_sh - trial);
          root_r <= {root_r[SI-2:0], 1'b1};
        end else begin
          srem_r <= SRW'(rem_sh);
          root_r <= {root_r[SI-2:0], 1'b0};
        end
      end
      OP_MSX: prod_r <= mul_a * mul_b;
      OP_MSY: begin
        prod_r   <= mul_a * mul_b;
        drem_x_r <= SI'(prod_r[2*W-1:W-1]);
        dq_x_r   <= prod_r[W-2:0];
      end
      OP_DINIT: begin
        drem_y_r <= SI'(prod_r[2*W-1:W-1]);
        dq_y_r   <= prod_r[W-2:0];
      end
      OP_DIV: begin
        if (dtx >= dvs) begin
          drem_x_r <= SI'(dtx - dvs);
          dq_x_r   <= {dq_x_r[QW-2:0], 1'b1};
        end else begin
          drem_x_r <= SI'(dtx);
          dq_x_r   <= {dq_x_r[QW-2:0], 1'b0};
        end
        if (dty >= dvs) begin
          drem_y_r <= SI'(dty - dvs);
          dq_y_r   <= {dq_y_r[QW-2:0], 1'b1};
        end else begin
          drem_y_r <= SI'(dty);
          dq_y_r   <= {dq_y_r[QW-2:0], 1'b0};
        end
      end
      OP_FIN: begin
        out_x_r   <= cur_x_nxt;
        out_y_r   <= cur_y_nxt;
        out_det_r <= det_nxt;
        out_arr_r <= arr_nxt;
      end
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_det   = out_det_r;
  assign out_arr   = out_arr_r;

  a_fin_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |=> out_valid_r)
    else $error("result not presented after finish");

  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DIV |-> root_r != '0)
    else $error("division by zero root");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN && cmd_r == CMD_MOVE && gt_r) |-> (dq_x_r <= step_r && dq_y_r <= step_r))
    else $error("advance exceeds step length");

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(cmd.op) != OP_FIN) |-> ($stable(cur_x_r) && $stable(cur_y_r)))
    else $error("position changed outside finish");

endmodule

>>> design/pursuit_step_and_range_detect.sv
// Pursuit step and range detector, top level. One request at a time.
// A request passes through load, delta, squares and compare; a move that steps
// also runs a square root, one bit per cycle (COORD_WIDTH+2 bits), and a two-lane
// restoring divide (COORD_WIDTH-1 quotient bits) before finish, which waits while
// the last result is untaken. The next request can be taken once the result is valid.
// Synchronous active-low reset: position 0, step length 0, radius 10.0.
module pursuit_step_and_range_detect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic        clk,
  input logic        rst_n,
  psr_in_if.sink     in_ch,
  psr_out_if.source  out_ch,
  psr_cfg_if.sink    cfg_ch
);
  import psr_pkg::*;

  psr_cmd_t  dp_cmd;
  psr_stat_t dp_stat;
  logic      ctl_in_ready;

  assign in_ch.ready  = ctl_in_ready;
  assign cfg_ch.ready = 1'b1;

  psr_ctrl #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  psr_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_cmd    (in_ch.cmd),
    .in_tx     (in_ch.target_x),
    .in_ty     (in_ch.target_y),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_x     (out_ch.pos_x),
    .out_y     (out_ch.pos_y),
    .out_det   (out_ch.detected),
    .out_arr   (out_ch.arrived)
  );

endmodule

>>> tb/tb_pursuit_step_and_range_detect.sv
// Self-checking bench for the pursuit step and range detector.
// Predicts each result from a model of the move, detect and place commands
// and checks it field by field. Needs psr_pkg and the three channel interfaces.
module tb_pursuit_step_and_range_detect;
  import psr_pkg::*;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int ONE_Q = 1 << FB;
  localparam logic [1:0] CMD_NOOP = 2'd3;
  localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
  localparam longint L_MAX = 64'sd2147483647;
  localparam longint L_MIN = -64'sd2147483648;
  localparam longint SPAN_CAP = 64'sd1073741824;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [CW-1:0]   tx;
    logic signed [CW-1:0]   ty;
  } chase_req_t;

  typedef struct packed {
    logic signed [CW-1:0]   pos_x;
    logic signed [CW-1:0]   pos_y;
    logic                   detected;
    logic                   arrived;
  } chase_res_t;

  logic clk = 1'b0;
  logic rst_n;

  psr_in_if  #(.COORD_WIDTH(CW)) in_ch  ();
  psr_out_if #(.COORD_WIDTH(CW)) out_ch ();
  psr_cfg_if #(.COORD_WIDTH(CW)) cfg_ch ();

  pursuit_step_and_range_detect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  chase_req_t           request_q[$];
  chase_res_t           outcome_q[$];
  chase_req_t           offered;
  logic signed [CW-1:0] cur_x = '0;
  logic signed [CW-1:0] cur_y = '0;
  logic [CW-2:0]        step_len = '0;
  logic [CW-2:0]        radius = 31'(10 << FB);
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   fail_cnt = 0;

  function automatic chase_res_t pursue(chase_req_t r);
    longint       dx, dy;
    logic [127:0] mx, my, dist2, root, trial, qx, qy;
    chase_res_t   res;
    dx = longint'(r.tx) - longint'(cur_x);
    dy = longint'(r.ty) - longint'(cur_y);
    mx = (dx < 0) ? 128'(-dx) : 128'(dx);
    my = (dy < 0) ? 128'(-dy) : 128'(dy);
    dist2 = mx * mx + my * my;
    res = '0;
    case (r.cmd)
      CMD_MOVE: begin
        if (dist2 > 128'(step_len) * 128'(step_len)) begin
          root = '0;
          for (int b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= dist2) root = trial;
          end
          qx = mx * 128'(step_len) / root;
          qy = my * 128'(step_len) / root;
          cur_x = (dx < 0) ? cur_x - qx[CW-1:0] : cur_x + qx[CW-1:0];
          cur_y = (dy < 0) ? cur_y - qy[CW-1:0] : cur_y + qy[CW-1:0];
        end else begin
          cur_x = r.tx;
          cur_y = r.ty;
          res.arrived = 1'b1;
        end
      end
      CMD_DETECT: res.detected = (dist2 <= 128'(radius) * 128'(radius));
      CMD_PLACE: begin
        cur_x = r.tx;
        cur_y = r.ty;
      end
      default: ;
    endcase
    res.pos_x = cur_x;
    res.pos_y = cur_y;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) outcome_q.push_back(pursue(offered));
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = request_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.cmd      <= offered.cmd;
          in_ch.target_x <= offered.tx;
          in_ch.target_y <= offered.ty;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    chase_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected result: pos (%0d, %0d) detected %0b arrived %0b", $time,
                   out_ch.pos_x, out_ch.pos_y, out_ch.detected, out_ch.arrived);
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (out_ch.pos_x !== want.pos_x) begin
            $display("%0t pos_x expected %0d got %0d", $time, want.pos_x, out_ch.pos_x);
            fail_cnt++;
          end
          if (out_ch.pos_y !== want.pos_y) begin
            $display("%0t pos_y expected %0d got %0d", $time, want.pos_y, out_ch.pos_y);
            fail_cnt++;
          end
          if (out_ch.detected !== want.detected) begin
            $display("%0t detected expected %0b got %0b", $time, want.detected,
                     out_ch.detected);
            fail_cnt++;
          end
          if (out_ch.arrived !== want.arrived) begin
            $display("%0t arrived expected %0b got %0b", $time, want.arrived, out_ch.arrived);
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_req(logic [1:0] c, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    request_q.push_back(chase_req_t'{cmd: c, tx: x, ty: y});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-2:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_STEP) step_len = val;
    else radius = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_ch.valid || outcome_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] clip(longint v);
    if (v > L_MAX) return C_MAX;
    if (v < L_MIN) return C_MIN;
    return v[CW-1:0];
  endfunction

  function automatic longint rand_off(longint span);
    longint v;
    v = longint'($urandom_range(0, 32'(span)));
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic longint rand_base();
    if ($urandom_range(3) == 0) return longint'(int'($urandom));
    return longint'($urandom_range(0, 1 << 25)) - longint'(1 << 24);
  endfunction

  function automatic logic [CW-2:0] pick_length();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 31'($urandom_range(1, 255));
      3: return 31'($urandom_range(256, 1 << 20));
      4: return 31'($urandom_range(1 << 20, 1 << 26));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic queue_pursuits(int n);
    int     made, kind, reps;
    longint span, bx, by, tx, ty, a, base;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99);
      bx = rand_base();
      by = rand_base();
      if (kind < 70) begin
        // place, chase a fixed target for a few steps, then probe near it
        span = longint'(step_len) * $urandom_range(1, 6) + $urandom_range(0, 255);
        if (span > SPAN_CAP) span = SPAN_CAP;
        tx = bx + rand_off(span);
        ty = by + rand_off(span);
        reps = $urandom_range(1, 8);
        push_req(CMD_PLACE, clip(bx), clip(by));
        repeat (reps) push_req(CMD_MOVE, clip(tx), clip(ty));
        push_req(CMD_DETECT, clip(tx + rand_off(longint'(radius) >> 1)),
                 clip(ty + rand_off(longint'(radius) >> 1)));
        made += reps + 2;
      end else if (kind < 85) begin
        // probe near the detection radius, or near 1/sqrt(2) of it, along an axis or the diagonal
        a = longint'(radius);
        if ($urandom_range(1)) a = (a * 46341) >> 16;
        base = -(a >> 1);
        if ($urandom_range(1)) begin
          push_req(CMD_PLACE, clip(base), clip(base));
          repeat (2) push_req(CMD_DETECT, clip(base + a + $urandom_range(0, 4) - 2),
                              clip(base + a + $urandom_range(0, 4) - 2));
        end else if ($urandom_range(1)) begin
          push_req(CMD_PLACE, clip(base), clip(by));
          repeat (2) push_req(CMD_DETECT, clip(base + a + $urandom_range(0, 4) - 2), clip(by));
        end else begin
          push_req(CMD_PLACE, clip(bx), clip(base));
          repeat (2) push_req(CMD_DETECT, clip(bx), clip(base + a + $urandom_range(0, 4) - 2));
        end
        made += 3;
      end else begin
        push_req(2'($urandom_range(0, 3)), $urandom, $urandom);
        made++;
      end
    end
  endtask

  int send_pcts[4] = '{0, 80, 0, 38};
  int recv_pcts[4] = '{0, 0, 80, 38};

  initial begin
    rst_n          <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_STEP;
    cfg_ch.data    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero step, radius 10.0
    push_req(CMD_DETECT, 10 * ONE_Q, 0);
    push_req(CMD_DETECT, 10 * ONE_Q, 1);
    push_req(CMD_DETECT, 6 * ONE_Q, -8 * ONE_Q);
    push_req(CMD_MOVE, 5 * ONE_Q, -5 * ONE_Q);
    push_req(CMD_MOVE, 0, 0);
    push_req(CMD_PLACE, C_MAX, C_MIN);
    push_req(CMD_NOOP, $urandom, $urandom);
    push_req(CMD_MOVE, C_MIN, C_MAX);
    push_req(CMD_DETECT, C_MIN, C_MAX);
    push_req(CMD_MOVE, C_MAX, C_MIN);
    drain();

    write_reg(REG_STEP, '1);
    write_reg(REG_RADIUS, '1);
    push_req(CMD_PLACE, C_MIN, C_MIN);
    repeat (3) push_req(CMD_MOVE, C_MAX, C_MAX);
    push_req(CMD_DETECT, C_MIN, C_MIN);
    push_req(CMD_DETECT, C_MAX, C_MAX);
    push_req(CMD_PLACE, C_MAX, C_MIN);
    repeat (2) push_req(CMD_MOVE, C_MIN, C_MAX);
    drain();

    write_reg(REG_STEP, 31'(ONE_Q));
    write_reg(REG_RADIUS, '0);
    push_req(CMD_PLACE, 0, 0);
    push_req(CMD_DETECT, 0, 0);
    push_req(CMD_DETECT, 1, 0);
    push_req(CMD_MOVE, 100 * ONE_Q, -37 * ONE_Q - ONE_Q / 2);
    push_req(CMD_MOVE, -1, -1);
    push_req(CMD_NOOP, C_MIN, C_MAX);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_STEP, pick_length());
      write_reg(REG_RADIUS, pick_length());
      send_idle_pct  = send_pcts[p % 4];
      recv_stall_pct = recv_pcts[p % 4];
      queue_pursuits(176);
      drain();
    end

    repeat (80) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
